// File: rtl/sbi_pkg.sv
// sbi_pkg: shared widths, CORDIC constants, divider figures and payload structs
// for the spherical bilinear interpolator. Depends on nothing.
package sbi_pkg;

	// field widths of one request and one result
	localparam int unsigned LAT_W = 24;
	localparam int unsigned LON_W = 26;
	localparam int unsigned VAL_W = 32;

	// cosine unit: degrees Q.24 angle, Q.30 rotation datapath
	localparam int unsigned INT_FRAC     = 24;
	localparam int unsigned CORDIC_STEPS = 20;
	localparam int unsigned XW           = 34;
	localparam int unsigned ZW           = 33;
	localparam int unsigned CW           = 30;
	localparam longint      CORDIC_GAIN  = 64'sd652032874;

	// rounding divider: quotient bits kept and its register stages
	localparam int unsigned DIV_QBITS = 35;
	localparam int unsigned DIV_EXTRA = 4;
	localparam int unsigned DIV_LAT   = DIV_QBITS + DIV_EXTRA;
	localparam int unsigned QUO_W     = DIV_QBITS + 2;

	// interpolation widths
	localparam int unsigned DX_W  = CW + 1;
	localparam int unsigned DY_W  = LON_W + 1;
	localparam int unsigned DV_W  = VAL_W + 1;
	localparam int unsigned ROW_W = 36;
	localparam int unsigned DB_W  = ROW_W + 1;
	localparam int unsigned NUM_W = 64;

	// arctangent of 2^-i in degrees Q.24
	function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0:    r = 33'sd754974720;
			5'd1:    r = 33'sd445687602;
			5'd2:    r = 33'sd235489088;
			5'd3:    r = 33'sd119537938;
			5'd4:    r = 33'sd60000934;
			5'd5:    r = 33'sd30029717;
			5'd6:    r = 33'sd15018523;
			5'd7:    r = 33'sd7509720;
			5'd8:    r = 33'sd3754917;
			5'd9:    r = 33'sd1877466;
			5'd10:   r = 33'sd938734;
			5'd11:   r = 33'sd469367;
			5'd12:   r = 33'sd234684;
			5'd13:   r = 33'sd117342;
			5'd14:   r = 33'sd58671;
			5'd15:   r = 33'sd29335;
			5'd16:   r = 33'sd14668;
			5'd17:   r = 33'sd7334;
			5'd18:   r = 33'sd3667;
			5'd19:   r = 33'sd1833;
			default: r = '0;
		endcase
		return r;
	endfunction

	// longitudes and corners riding beside the cosine lanes
	typedef struct packed {
		logic signed [LON_W-1:0] lon_low;
		logic signed [LON_W-1:0] lon_high;
		logic signed [LON_W-1:0] query_lon;
		logic signed [VAL_W-1:0] corner_ll;
		logic signed [VAL_W-1:0] corner_lh;
		logic signed [VAL_W-1:0] corner_hl;
		logic signed [VAL_W-1:0] corner_hh;
	} side_t;

	// carried beside the first pair of divisions
	typedef struct packed {
		logic signed [VAL_W-1:0] v11;
		logic signed [VAL_W-1:0] v12;
		logic signed [DY_W-1:0]  ey;
		logic signed [DY_W-1:0]  dy;
		logic                    deg;
	} mid_t;

	// carried beside the last division
	typedef struct packed {
		logic signed [ROW_W-1:0] a;
		logic                    deg;
	} late_t;

endpackage

// File: rtl/sbi_if.sv
// sbi_if: request and result channels of the interpolator (valid/ready).
// Depends on sbi_pkg for the field widths.
interface sbi_req_if;
	import sbi_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [LAT_W-1:0] lat_low;
	logic signed [LAT_W-1:0] lat_high;
	logic signed [LON_W-1:0] lon_low;
	logic signed [LON_W-1:0] lon_high;
	logic signed [LAT_W-1:0] query_lat;
	logic signed [LON_W-1:0] query_lon;
	logic signed [VAL_W-1:0] corner_ll;
	logic signed [VAL_W-1:0] corner_lh;
	logic signed [VAL_W-1:0] corner_hl;
	logic signed [VAL_W-1:0] corner_hh;
	modport source (output valid, lat_low, lat_high, lon_low, lon_high, query_lat,
		query_lon, corner_ll, corner_lh, corner_hl, corner_hh, input ready);
	modport sink (input valid, lat_low, lat_high, lon_low, lon_high, query_lat,
		query_lon, corner_ll, corner_lh, corner_hl, corner_hh, output ready);
endinterface

interface sbi_res_if;
	import sbi_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] interpolated;
	logic                    degenerate;
	modport source (output valid, interpolated, degenerate, input ready);
	modport sink (input valid, interpolated, degenerate, output ready);
endinterface

// File: rtl/spherical_bilinear_interpolation.sv
// spherical_bilinear_interpolation: top level of the interpolator.
// Depends on sbi_pkg, sbi_req_if / sbi_res_if and sbi_div.
//
// Usage: each request on req carries a cell (two latitudes, two longitudes),
// its four corner values and a query point. The result on res is the value
// interpolated bilinearly in x = cos(90 - latitude) and y = longitude,
// saturated to 32 bits, with degenerate set (and the value 0) when the two
// cosines or the two longitudes of the cell are equal.
// Throughput: one request per cycle while the pipeline is not stalled. The result
// reaches the output register through the 7-stage angle reduction, the
// 20-stage CORDIC for the cosines and two 39-stage rounding dividers
// (one quotient bit per restoring step) in series.
// Reset clears all valid bits, the result valid included; payload and the output value are not reset.
// When res stalls, the result is held in the output register and the
// pipeline keeps moving as long as its last stage is empty; only a full last
// stage behind a held result stalls every stage, and then req.ready drops.
module spherical_bilinear_interpolation #(
	parameter int unsigned ANGLE_FRAC_BITS = 16
) (
	input logic      clk,
	input logic      arst_n,
	sbi_req_if.sink  req,
	sbi_res_if.source res
);
	import sbi_pkg::*;

	// angle reduction constants
	localparam int unsigned WW      = 34;
	localparam int unsigned DW      = 33;
	localparam longint      PERIOD  = longint'(360) << ANGLE_FRAC_BITS;
	localparam longint      QUARTER = longint'(90) << ANGLE_FRAC_BITS;
	localparam longint      OFFSET  =
		PERIOD * (((longint'(1) << (LAT_W - 1)) + PERIOD - 1) / PERIOD);
	localparam longint      W_BIAS  = QUARTER + OFFSET;
	localparam longint      RECIP   = (longint'(1) << WW) / PERIOD;
	localparam int unsigned RW      = $clog2(RECIP + 1);
	localparam int unsigned SH      = INT_FRAC - ANGLE_FRAC_BITS;
	localparam longint      D_FULL  = longint'(360) << INT_FRAC;
	localparam longint      D_HALF  = longint'(180) << INT_FRAC;
	localparam longint      D_QUART = longint'(90) << INT_FRAC;
	localparam longint      COS_ONE = longint'(1) << 28;
	localparam longint      ROW_LIM = longint'(1) << 34;
	localparam longint      OUT_HI  = (longint'(1) << 31) - 1;
	localparam longint      OUT_LO  = -(longint'(1) << 31);

	// stage numbering
	localparam int unsigned S_RED = 7;
	localparam int unsigned S_X   = S_RED + CORDIC_STEPS + 2;
	localparam int unsigned S_MUL = S_X + 2;
	localparam int unsigned NST   = S_MUL + DIV_LAT + 3 + DIV_LAT;

	logic            adv;
	logic [NST:1]    vld_s;
	logic            res_vld_q;
	logic signed [VAL_W-1:0] interp_q;
	logic            deg_q;

	// whole pipeline advances unless a full last stage meets a held result
	assign adv       = !vld_s[NST] || !res_vld_q || res.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-1:1], req.valid};
		end
	end

	// ---------------- latitude lanes: 0 low, 1 high, 2 query ----------------
	logic signed [LAT_W-1:0] lat_in [3];
	always_comb begin
		lat_in[0] = req.lat_low;
		lat_in[1] = req.lat_high;
		lat_in[2] = req.query_lat;
	end

	logic [WW-1:0]         w_s1 [3], w_s2 [3], w_s3 [3], qp_s3 [3], r_s4 [3];
	logic [WW+RW-1:0]      prod_s2 [3];
	logic [WW-1:0]         m_c [3];
	logic [DW-1:0]         d_s5 [3], d_s6 [3];
	logic signed [XW-1:0]  cx_s [3][CORDIC_STEPS+1];
	logic signed [XW-1:0]  cy_s [3][CORDIC_STEPS+1];
	logic signed [ZW-1:0]  cz_s [3][CORDIC_STEPS+1];
	logic                  cn_s [3][CORDIC_STEPS+1];
	logic signed [XW-1:0]  t_c [3];
	logic [28:0]           c_s28 [3];
	logic                  cneg_s28 [3];
	logic signed [CW-1:0]  x_s29 [3];

	for (genvar l = 0; l < 3; l++) begin : g_lane
		// colatitude biased positive, then reduced modulo one turn
		always_ff @(posedge clk) begin
			if (adv) begin
				w_s1[l]    <= WW'(W_BIAS) - WW'(lat_in[l]);
				prod_s2[l] <= (WW+RW)'(w_s1[l]) * (WW+RW)'(RECIP);
				w_s2[l]    <= w_s1[l];
				qp_s3[l]   <= WW'(prod_s2[l][WW+RW-1:WW]) * WW'(PERIOD);
				w_s3[l]    <= w_s2[l];
				r_s4[l]    <= w_s3[l] - qp_s3[l];
			end
		end

		// one correction, then scale to degrees Q.24
		always_comb begin
			m_c[l] = (r_s4[l] >= WW'(PERIOD)) ? r_s4[l] - WW'(PERIOD) : r_s4[l];
		end

		// fold into the first quadrant
		always_ff @(posedge clk) begin
			if (adv) begin
				d_s5[l] <= DW'(m_c[l]) << SH;
				d_s6[l] <= (d_s5[l] > DW'(D_HALF)) ? DW'(D_FULL) - d_s5[l] : d_s5[l];
				if (d_s6[l] > DW'(D_QUART)) begin
					cz_s[l][0] <= $signed(DW'(D_HALF) - d_s6[l]);
					cn_s[l][0] <= 1'b1;
				end else begin
					cz_s[l][0] <= $signed(d_s6[l]);
					cn_s[l][0] <= 1'b0;
				end
				cx_s[l][0] <= XW'(CORDIC_GAIN);
				cy_s[l][0] <= '0;
			end
		end

		// rotation CORDIC, one step per stage
		for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
			always_ff @(posedge clk) begin
				if (adv) begin
					if (cz_s[l][i] >= 0) begin
						cx_s[l][i+1] <= cx_s[l][i] - (cy_s[l][i] >>> i);
						cy_s[l][i+1] <= cy_s[l][i] + (cx_s[l][i] >>> i);
						cz_s[l][i+1] <= cz_s[l][i] - atan_deg(5'(i));
					end else begin
						cx_s[l][i+1] <= cx_s[l][i] + (cy_s[l][i] >>> i);
						cy_s[l][i+1] <= cy_s[l][i] - (cx_s[l][i] >>> i);
						cz_s[l][i+1] <= cz_s[l][i] + atan_deg(5'(i));
					end
					cn_s[l][i+1] <= cn_s[l][i];
				end
			end
		end

		// round to Q.28, clamp, then restore the sign
		always_comb begin
			t_c[l] = (cx_s[l][CORDIC_STEPS] + XW'(2)) >>> 2;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (t_c[l] < 0) begin
					c_s28[l] <= '0;
				end else if (t_c[l] > XW'(COS_ONE)) begin
					c_s28[l] <= 29'(COS_ONE);
				end else begin
					c_s28[l] <= 29'(t_c[l]);
				end
				cneg_s28[l] <= cn_s[l][CORDIC_STEPS];
				x_s29[l] <= cneg_s28[l] ? -$signed(CW'(c_s28[l])) : $signed(CW'(c_s28[l]));
			end
		end
	end

	// ---------------- longitudes and corners beside the lanes ----------------
	side_t side_s [1:S_X];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[1] <= '{lon_low: req.lon_low, lon_high: req.lon_high,
				query_lon: req.query_lon, corner_ll: req.corner_ll,
				corner_lh: req.corner_lh, corner_hl: req.corner_hl,
				corner_hh: req.corner_hh};
		end
	end

	for (genvar k = 2; k <= S_X; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// ---------------- differences ----------------
	logic signed [DX_W-1:0] dx_s30, ex_s30, dx_s31;
	logic signed [DV_W-1:0] dv1_s30, dv2_s30;
	logic signed [NUM_W-1:0] n1_s31, n2_s31;
	mid_t mid_s30;
	mid_t mid_d [DIV_LAT+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s30      <= DX_W'(x_s29[1]) - DX_W'(x_s29[0]);
			ex_s30      <= DX_W'(x_s29[2]) - DX_W'(x_s29[0]);
			dv1_s30     <= DV_W'(side_s[S_X].corner_hl) - DV_W'(side_s[S_X].corner_ll);
			dv2_s30     <= DV_W'(side_s[S_X].corner_hh) - DV_W'(side_s[S_X].corner_lh);
			mid_s30.v11 <= side_s[S_X].corner_ll;
			mid_s30.v12 <= side_s[S_X].corner_lh;
			mid_s30.ey  <= DY_W'(side_s[S_X].query_lon) - DY_W'(side_s[S_X].lon_low);
			mid_s30.dy  <= DY_W'(side_s[S_X].lon_high) - DY_W'(side_s[S_X].lon_low);
			mid_s30.deg <= (x_s29[1] == x_s29[0]) ||
				(side_s[S_X].lon_high == side_s[S_X].lon_low);
		end
	end

	// numerators along x
	always_ff @(posedge clk) begin
		if (adv) begin
			n1_s31   <= NUM_W'(ex_s30) * NUM_W'(dv1_s30);
			n2_s31   <= NUM_W'(ex_s30) * NUM_W'(dv2_s30);
			dx_s31   <= dx_s30;
			mid_d[0] <= mid_s30;
		end
	end

	for (genvar k = 1; k <= DIV_LAT; k++) begin : g_mid
		always_ff @(posedge clk) begin
			if (adv) begin
				mid_d[k] <= mid_d[k-1];
			end
		end
	end

	logic signed [QUO_W-1:0] q1, q2, q3;

	sbi_div #(.NUMW(NUM_W), .DENW(DX_W), .QBITS(DIV_QBITS)) u_div_a (
		.clk (clk), .en (adv), .num (n1_s31), .den (dx_s31), .quo (q1)
	);

	sbi_div #(.NUMW(NUM_W), .DENW(DX_W), .QBITS(DIV_QBITS)) u_div_b (
		.clk (clk), .en (adv), .num (n2_s31), .den (dx_s31), .quo (q2)
	);

	// ---------------- row values a and b, clamped ----------------
	logic signed [ROW_W+1:0] sa_c, sb_c;
	logic signed [ROW_W-1:0] a_s71, b_s71, a_s72;
	logic signed [DB_W-1:0]  db_s72;
	logic signed [DY_W-1:0]  ey_s71, dy_s71, ey_s72, dy_s72, dy_s73;
	logic                    deg_s71, deg_s72;
	logic signed [NUM_W-1:0] n3_s73;
	late_t late_d [DIV_LAT+1];

	always_comb begin
		sa_c = (ROW_W+2)'(mid_d[DIV_LAT].v11) + (ROW_W+2)'(q1);
		sb_c = (ROW_W+2)'(mid_d[DIV_LAT].v12) + (ROW_W+2)'(q2);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (sa_c > (ROW_W+2)'(ROW_LIM)) begin
				a_s71 <= ROW_W'(ROW_LIM);
			end else if (sa_c < -(ROW_W+2)'(ROW_LIM)) begin
				a_s71 <= -ROW_W'(ROW_LIM);
			end else begin
				a_s71 <= ROW_W'(sa_c);
			end
			if (sb_c > (ROW_W+2)'(ROW_LIM)) begin
				b_s71 <= ROW_W'(ROW_LIM);
			end else if (sb_c < -(ROW_W+2)'(ROW_LIM)) begin
				b_s71 <= -ROW_W'(ROW_LIM);
			end else begin
				b_s71 <= ROW_W'(sb_c);
			end
			ey_s71  <= mid_d[DIV_LAT].ey;
			dy_s71  <= mid_d[DIV_LAT].dy;
			deg_s71 <= mid_d[DIV_LAT].deg;
		end
	end

	// step along y
	always_ff @(posedge clk) begin
		if (adv) begin
			db_s72  <= DB_W'(b_s71) - DB_W'(a_s71);
			a_s72   <= a_s71;
			ey_s72  <= ey_s71;
			dy_s72  <= dy_s71;
			deg_s72 <= deg_s71;
			n3_s73  <= NUM_W'(ey_s72) * NUM_W'(db_s72);
			dy_s73  <= dy_s72;
			late_d[0] <= '{a: a_s72, deg: deg_s72};
		end
	end

	for (genvar k = 1; k <= DIV_LAT; k++) begin : g_late
		always_ff @(posedge clk) begin
			if (adv) begin
				late_d[k] <= late_d[k-1];
			end
		end
	end

	sbi_div #(.NUMW(NUM_W), .DENW(DY_W), .QBITS(DIV_QBITS)) u_div_y (
		.clk (clk), .en (adv), .num (n3_s73), .den (dy_s73), .quo (q3)
	);

	// ---------------- output register ----------------
	logic signed [ROW_W+1:0] r_c;
	always_comb begin
		r_c = (ROW_W+2)'(late_d[DIV_LAT].a) + (ROW_W+2)'(q3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv && vld_s[NST]) begin
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s[NST]) begin
			deg_q <= late_d[DIV_LAT].deg;
			if (late_d[DIV_LAT].deg) begin
				interp_q <= '0;
			end else if (r_c > (ROW_W+2)'(OUT_HI)) begin
				interp_q <= VAL_W'(OUT_HI);
			end else if (r_c < (ROW_W+2)'(OUT_LO)) begin
				interp_q <= VAL_W'(OUT_LO);
			end else begin
				interp_q <= VAL_W'(r_c);
			end
		end
	end

	assign res.valid        = res_vld_q;
	assign res.interpolated = interp_q;
	assign res.degenerate   = deg_q;

	// ---------------- checks ----------------
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && deg_q |-> interp_q == '0)
		else $error("degenerate result with nonzero value");

	a_last_held: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NST] && !adv |=> vld_s[NST])
		else $error("last pipeline stage dropped a request while stalled");

	a_presented: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s[NST] |=> res_vld_q)
		else $error("finished request not presented on the result channel");

endmodule

// File: rtl/sbi_div.sv
// sbi_div: pipelined signed division rounding to nearest (ties away from zero),
// one restoring quotient bit per stage, quotient capped at 2^QBITS. Uses sbi_pkg.
module sbi_div #(
	parameter int unsigned NUMW  = 64,
	parameter int unsigned DENW  = 31,
	parameter int unsigned QBITS = 35
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [NUMW-1:0]  num,
	input  logic signed [DENW-1:0]  den,
	output logic signed [QBITS+1:0] quo
);
	import sbi_pkg::*;

	localparam int unsigned MW = NUMW + 1;
	localparam int unsigned RW = (MW > DENW + QBITS) ? MW : DENW + QBITS;

	logic signed [NUMW:0] nx;
	logic signed [DENW:0] dxt;
	logic [MW-1:0]        un_s1;
	logic [DENW-1:0]      ud_s1, ud_s2;
	logic                 neg_s1, neg_s2;
	logic [RW-1:0]        sum_s2;
	logic [RW-1:0]        rem_s [QBITS+1];
	logic [DENW-1:0]      ud_s  [QBITS+1];
	logic [QBITS-1:0]     q_s   [QBITS+1];
	logic                 neg_s [QBITS+1];
	logic                 ovf_s [QBITS+1];
	logic [QBITS:0]       mag;

	// magnitudes and result sign
	always_comb begin
		nx  = (NUMW+1)'(num);
		dxt = (DENW+1)'(den);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			un_s1  <= MW'(nx[NUMW] ? -nx : nx);
			ud_s1  <= DENW'(dxt[DENW] ? -dxt : dxt);
			neg_s1 <= num[NUMW-1] ^ den[DENW-1];
		end
	end

	// add half the divisor for rounding
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= RW'(un_s1) + RW'(ud_s1 >> 1);
			ud_s2  <= ud_s1;
			neg_s2 <= neg_s1;
		end
	end

	// quotient cap check
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= sum_s2;
			ud_s[0]  <= ud_s2;
			neg_s[0] <= neg_s2;
			ovf_s[0] <= sum_s2 >= (RW'(ud_s2) << QBITS);
			q_s[0]   <= '0;
		end
	end

	// one restoring step per stage, most significant quotient bit first
	for (genvar j = 0; j < QBITS; j++) begin : g_step
		logic [RW-1:0] t;
		logic          ge;
		always_comb begin
			t  = RW'(ud_s[j]) << (QBITS - 1 - j);
			ge = rem_s[j] >= t;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? rem_s[j] - t : rem_s[j];
				q_s[j+1]   <= {q_s[j][QBITS-2:0], ge};
				ud_s[j+1]  <= ud_s[j];
				neg_s[j+1] <= neg_s[j];
				ovf_s[j+1] <= ovf_s[j];
			end
		end
	end

	// saturate and apply sign
	always_comb begin
		mag = ovf_s[QBITS] ? ((QBITS+1)'(1) << QBITS) : {1'b0, q_s[QBITS]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= neg_s[QBITS] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

endmodule

// File: tb/tb_spherical_bilinear_interpolation.sv
// Self-checking testbench for spherical_bilinear_interpolation: directed and random
// requests, a bit-true interpolation predictor and a result scoreboard.
// Depends on sbi_pkg, sbi_req_if / sbi_res_if and the block itself.
module tb_spherical_bilinear_interpolation;
	timeunit 1ns;
	timeprecision 1ps;
	import sbi_pkg::*;

	localparam int  ANG_FRAC    = 16;
	localparam int  IDLE_LIMIT  = 3000;
	localparam int  DRAIN       = 150;
	localparam int  RAND_CELLS  = 600;
	localparam int  QUIET_FROM  = 480;
	localparam longint ROW_SAT  = 64'sd1 << 34;
	localparam longint DEG      = 64'sd1 << ANG_FRAC;
	localparam longint ATAN_Q24 [CORDIC_STEPS] = '{
		754974720, 445687602, 235489088, 119537938, 60000934,
		30029717, 15018523, 7509720, 3754917, 1877466,
		938734, 469367, 234684, 117342, 58671,
		29335, 14668, 7334, 3667, 1833};

	typedef struct {
		logic signed [LAT_W-1:0] lat_low, lat_high, query_lat;
		logic signed [LON_W-1:0] lon_low, lon_high, query_lon;
		logic signed [VAL_W-1:0] corner_ll, corner_lh, corner_hl, corner_hh;
	} cell_t;

	typedef struct {
		logic signed [VAL_W-1:0] interpolated;
		logic                    degenerate;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	sbi_req_if req ();
	sbi_res_if res ();

	spherical_bilinear_interpolation dut (.clk(clk), .arst_n(arst_n), .req(req), .res(res));

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp64(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// divide, rounding to nearest with ties away from zero
	function automatic longint div_nearest(longint n, longint d);
		longint unsigned un, ud, q;
		un = n < 0 ? -n : n;
		ud = d < 0 ? -d : d;
		q = (un + ud / 2) / ud;
		return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
	endfunction

	// cos(90 - lat) in Q.28 by the 20-step rotation CORDIC
	function automatic longint colat_cos(longint lat);
		longint period, m, d, x, y, z, nx, c;
		bit neg;
		period = 64'sd360 * DEG;
		m = (64'sd90 * DEG - lat) % period;
		if (m < 0)
			m += period;
		d = m * (64'sd1 << (INT_FRAC - ANG_FRAC));
		neg = 1'b0;
		if (d > (64'sd180 << INT_FRAC))
			d = (64'sd360 << INT_FRAC) - d;
		if (d > (64'sd90 << INT_FRAC)) begin
			d = (64'sd180 << INT_FRAC) - d;
			neg = 1'b1;
		end
		x = CORDIC_GAIN;
		y = 0;
		z = d;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= ATAN_Q24[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += ATAN_Q24[i];
			end
			x = nx;
		end
		c = clamp64((x + 2) >>> 2, 0, 64'sd1 << 28);
		return neg ? -c : c;
	endfunction

	function automatic outcome_t interpolate(cell_t q);
		outcome_t o;
		longint x1, x2, x0, y1, y2, y0, v11, v12, v21, v22, a, b, r;
		x1 = colat_cos(q.lat_low);
		x2 = colat_cos(q.lat_high);
		x0 = colat_cos(q.query_lat);
		y1 = q.lon_low;
		y2 = q.lon_high;
		y0 = q.query_lon;
		v11 = q.corner_ll;
		v12 = q.corner_lh;
		v21 = q.corner_hl;
		v22 = q.corner_hh;
		if (x2 == x1 || y2 == y1) begin
			o.interpolated = '0;
			o.degenerate = 1'b1;
			return o;
		end
		// along x first (rows clipped), then along y
		a = clamp64(v11 + div_nearest((x0 - x1) * (v21 - v11), x2 - x1), -ROW_SAT, ROW_SAT);
		b = clamp64(v12 + div_nearest((x0 - x1) * (v22 - v12), x2 - x1), -ROW_SAT, ROW_SAT);
		r = a + div_nearest((y0 - y1) * (b - a), y2 - y1);
		r = clamp64(r, -(64'sd1 << 31), (64'sd1 << 31) - 1);
		o.interpolated = r[VAL_W-1:0];
		o.degenerate = 1'b0;
		return o;
	endfunction

	// expected results in request order
	class interp_scoreboard;
		outcome_t pending[$];
		int errors = 0;
		int checked = 0;
		int degenerates = 0;

		function void note_request(cell_t q);
			pending.push_back(interpolate(q));
		endfunction

		task report(string what);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, what);
		endtask

		task check_result(logic signed [VAL_W-1:0] value, logic deg);
			outcome_t e;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result %0d deg %0b", value, deg));
				return;
			end
			e = pending.pop_front();
			checked++;
			if (deg)
				degenerates++;
			if (deg !== e.degenerate)
				report($sformatf("degenerate %0b, expected %0b", deg, e.degenerate));
			if (value !== e.interpolated)
				report($sformatf("interpolated %0d, expected %0d", value, e.interpolated));
		endtask
	endclass

	interp_scoreboard board = new();
	int sent = 0;
	bit quiet = 1'b0;
	int idle_cycles = 0;

	// request side
	task automatic drive_request(cell_t q);
		int gap;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			req.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.lat_low = q.lat_low;
		req.lat_high = q.lat_high;
		req.query_lat = q.query_lat;
		req.lon_low = q.lon_low;
		req.lon_high = q.lon_high;
		req.query_lon = q.query_lon;
		req.corner_ll = q.corner_ll;
		req.corner_lh = q.corner_lh;
		req.corner_hl = q.corner_hl;
		req.corner_hh = q.corner_hh;
		req.valid = 1'b1;
		do @(posedge clk); while (!req.ready);
		board.note_request(q);
		sent++;
	endtask

	function automatic longint span(longint lo, longint hi);
		return lo + longint'($urandom_range(0, 32'(hi - lo)));
	endfunction

	function automatic cell_t make_cell(longint lat1, longint lat2, longint qlat,
			longint lon1, longint lon2, longint qlon, longint v1, longint v2,
			longint v3, longint v4);
		cell_t q;
		q.lat_low = lat1[LAT_W-1:0];
		q.lat_high = lat2[LAT_W-1:0];
		q.query_lat = qlat[LAT_W-1:0];
		q.lon_low = lon1[LON_W-1:0];
		q.lon_high = lon2[LON_W-1:0];
		q.query_lon = qlon[LON_W-1:0];
		q.corner_ll = v1[VAL_W-1:0];
		q.corner_lh = v2[VAL_W-1:0];
		q.corner_hl = v3[VAL_W-1:0];
		q.corner_hh = v4[VAL_W-1:0];
		return q;
	endfunction

	// a plausible grid cell with the query mostly inside it
	function automatic cell_t grid_cell();
		longint la, lb, lo, lp, ql, qo;
		la = span(-90 * DEG, 80 * DEG);
		lb = la + span(1, 10 * DEG);
		lo = span(-180 * DEG, 350 * DEG);
		lp = lo + span(1, 10 * DEG);
		ql = ($urandom_range(0, 4) == 0) ? span(-90 * DEG, 90 * DEG) : span(la, lb);
		qo = ($urandom_range(0, 4) == 0) ? span(-180 * DEG, 360 * DEG) : span(lo, lp);
		if ($urandom_range(0, 1))
			return make_cell(la, lb, ql, lo, lp, qo, span(-100000000, 100000000),
				span(-100000000, 100000000), span(-100000000, 100000000),
				span(-100000000, 100000000));
		return make_cell(lb, la, ql, lp, lo, qo, $urandom, $urandom, $urandom, $urandom);
	endfunction

	// any bit pattern the fields allow
	function automatic cell_t noise_cell();
		return make_cell($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom);
	endfunction

	// result side: random back-pressure in bursts
	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left > 0)
			stall_left <= stall_left - 1;
		else if (!quiet && $urandom_range(0, 4) == 0)
			stall_left <= $urandom_range(1, 7);
		res.ready <= quiet || (stall_left == 0 && $urandom_range(0, 4) != 0);
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			board.check_result(res.interpolated, res.degenerate);
	end

	// watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (res.valid && res.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired, %0d results outstanding", board.pending.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		longint big;
		req.valid = 1'b0;
		req.lat_low = '0;
		req.lat_high = '0;
		req.query_lat = '0;
		req.lon_low = '0;
		req.lon_high = '0;
		req.query_lon = '0;
		req.corner_ll = '0;
		req.corner_lh = '0;
		req.corner_hl = '0;
		req.corner_hh = '0;
		res.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		big = 64'sd2147483647;
		// plain cell inside the range
		drive_request(make_cell(10 * DEG, 20 * DEG, 15 * DEG, 30 * DEG, 40 * DEG, 35 * DEG,
			1 * DEG, 2 * DEG, 3 * DEG, 4 * DEG));
		// field extremes, poles and the longitude span ends
		drive_request(make_cell(-90 * DEG, 90 * DEG, 0, -180 * DEG, 360 * DEG, 0,
			-big - 1, big, -big - 1, big));
		drive_request(make_cell(90 * DEG, -90 * DEG, 90 * DEG, 360 * DEG, -180 * DEG,
			360 * DEG, big, big, big, big));
		drive_request(make_cell(-90 * DEG, 90 * DEG, -90 * DEG, -180 * DEG, 360 * DEG,
			-180 * DEG, -big - 1, -big - 1, -big - 1, -big - 1));
		// zero delta: equal latitudes, equal longitudes, both
		drive_request(make_cell(30 * DEG, 30 * DEG, 31 * DEG, 0, DEG, 0, 5, 6, 7, 8));
		drive_request(make_cell(30 * DEG, 40 * DEG, 31 * DEG, DEG, DEG, 0, 5, 6, 7, 8));
		drive_request(make_cell(-5, -5, 0, 7, 7, 0, big, big, big, big));
		// latitudes beyond the pole wrap through the period
		drive_request(make_cell(-8388608, 8388607, 100 * DEG, 0, DEG, 2 * DEG, 0, big, 0, -big));
		drive_request(make_cell(120 * DEG, 60 * DEG, -127 * DEG, -DEG, DEG, 0, 1, 2, 3, 4));
		// raw field extremes on the longitudes
		drive_request(make_cell(0, DEG, 0, -33554432, 33554431, 0, 9, -9, 9, -9));
		// query far outside: row clip and result saturation
		drive_request(make_cell(0, 1, 90 * DEG, 0, 1, 33554431, -big - 1, big, big, -big - 1));
		drive_request(make_cell(1, 0, -90 * DEG, 1, 0, -33554432, big, -big - 1, -big - 1, big));
		drive_request(make_cell(0, 10 * DEG, 90 * DEG, 0, DEG, 100 * DEG, 0, 0, big, big));
		drive_request(make_cell(0, 10 * DEG, -90 * DEG, 0, DEG, -100 * DEG, 0, 0, big, -big));
		// nearly equal cosines near the pole
		drive_request(make_cell(90 * DEG - 1, 90 * DEG, 45 * DEG, 0, 1, 3, 100, 200, 300, 400));

		for (int i = 0; i < RAND_CELLS; i++) begin
			if (i == QUIET_FROM)
				quiet = 1'b1;
			drive_request(($urandom_range(0, 4) == 0) ? noise_cell() : grid_cell());
		end
		@(negedge clk);
		req.valid = 1'b0;

		// wait for the pipeline to empty; the watchdog covers a hang
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		$display("%0d requests sent, %0d results checked, %0d of them degenerate",
			sent, board.checked, board.degenerates);
		$display("cells covered pole, wrapped, extrapolated and saturating cases");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
